// File: hw/rtl/grid_dda_ray_caster_macros.svh
// assertion macros used by the ray caster back end rtl
`ifndef GRID_DDA_RAY_CASTER_MACROS_SVH
`define GRID_DDA_RAY_CASTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GDRC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdrc implication check failed");
// next-cycle implication
`define GDRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdrc next-cycle check failed");
`else
`define GDRC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define GDRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/gdrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gdrc_pkg;

   localparam int MAP_WIDTH   = 64;
   localparam int MAP_HEIGHT  = 64;
   localparam int FRAC_BITS   = 10;
   localparam int MAP_X_BITS  = $clog2(MAP_WIDTH);
   localparam int MAP_Y_BITS  = $clog2(MAP_HEIGHT);
   localparam int MAP_ADDR_W  = MAP_X_BITS + MAP_Y_BITS;
   localparam int MAP_DEPTH   = MAP_WIDTH * MAP_HEIGHT;

   localparam int CELL_W      = 6;
   localparam int CODE_W      = 8;
   localparam int POS_W       = 16;
   localparam int RAY_W       = 16;
   localparam int RAY_FRAC    = 14;
   localparam int DIST_W      = 18;
   localparam int CSR_IDX_W   = 8;

   localparam int COORD_W     = POS_W - FRAC_BITS + 2;
   localparam int SQ_W        = 2 * RAY_W;
   localparam int RAD_W       = SQ_W + 2 * FRAC_BITS;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int DIVD_W      = 32;
   localparam int DIVS_W      = RAY_W;
   localparam int OFS_W       = FRAC_BITS + 1;
   localparam int SIDE_PROD_W = OFS_W + DIST_W;
   localparam int SIDE_W      = 26;
   localparam int EDGE_W      = COORD_W + FRAC_BITS + 1;
   localparam int FIFO_DEPTH  = 2;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [OFS_W-1:0]  ONE_UNIT = OFS_W'(1) << FRAC_BITS;

   localparam logic [CODE_W-1:0] CODE_WALL = 8'd49;
   localparam logic [CODE_W-1:0] CODE_DOOR = 8'd53;
   localparam logic [CODE_W-1:0] DOOR_OPENED_RESET = 8'd50;
   localparam logic [CODE_W-1:0] DOOR_SIDE_RESET   = 8'd51;

   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_OPENED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_SIDE   = 8'd1;

   typedef enum logic {
      OP_WRITE,
      OP_CAST
   } gdrc_op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SQ_X, ST_SQ_SUM, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_DIVX_GO, ST_DIVX_WAIT, ST_DIVY_GO, ST_DIVY_WAIT, ST_SIDE_X, ST_SIDE_Y,
      ST_STEP, ST_CHECK, ST_NEIGH, ST_PERP_GO, ST_PERP_WAIT, ST_DONE
   } gdrc_state_type;

   typedef struct packed {
      gdrc_op_type        op;
      logic [CELL_W-1:0]  cell_x;
      logic [CELL_W-1:0]  cell_y;
      logic [CODE_W-1:0]  cell_code;
      logic [POS_W-1:0]   player_x;
      logic [POS_W-1:0]   player_y;
      logic [DIVS_W-1:0]  mag_x;
      logic [DIVS_W-1:0]  mag_y;
      logic               neg_x;
      logic               neg_y;
   } gdrc_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] door_opened_code;
      logic [CODE_W-1:0] door_side_code;
   } gdrc_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gdrc_unit_stat_type;

   function automatic logic [DIST_W-1:0] sat_dist(input logic [DIVD_W-1:0] v);
      return (v > DIVD_W'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
   endfunction

   function automatic logic cell_inside(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y);
      return !x[COORD_W-1] && (x < COORD_W'(MAP_WIDTH)) &&
             !y[COORD_W-1] && (y < COORD_W'(MAP_HEIGHT));
   endfunction

   function automatic logic [MAP_ADDR_W-1:0] map_addr(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y);
      return {y[MAP_Y_BITS-1:0], x[MAP_X_BITS-1:0]};
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gdrc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gdrc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [5:0]  cell_x;
   logic [5:0]  cell_y;
   logic [7:0]  cell_code;
   logic [15:0] player_x;
   logic [15:0] player_y;
   logic signed [15:0] ray_x;
   logic signed [15:0] ray_y;

   modport source (output valid, cmd, cell_x, cell_y, cell_code, player_x, player_y,
                   ray_x, ray_y, input ready);
   modport sink (input valid, cmd, cell_x, cell_y, cell_code, player_x, player_y,
                 ray_x, ray_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gdrc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gdrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit_found;
   logic [5:0]  hit_cell_x;
   logic [5:0]  hit_cell_y;
   logic        hit_y_side;
   logic [7:0]  target_code;
   logic [17:0] perp_dist;
   logic [17:0] side_dist_x;
   logic [17:0] side_dist_y;

   modport source (output valid, hit_found, hit_cell_x, hit_cell_y, hit_y_side,
                   target_code, perp_dist, side_dist_x, side_dist_y, input ready);
   modport sink (input valid, hit_found, hit_cell_x, hit_cell_y, hit_y_side,
                 target_code, perp_dist, side_dist_x, side_dist_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gdrc_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gdrc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gdrc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gdrc_front
   import gdrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   gdrc_req_if.sink     req,
   input  wire logic    item_pop,
   output logic         item_valid,
   output gdrc_item_type item_head
);

   gdrc_item_type entry_ff [FIFO_DEPTH];
   logic [$clog2(FIFO_DEPTH)-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [$clog2(FIFO_DEPTH+1)-1:0] count_ff, count_in;
   gdrc_item_type item_new;
   logic push, pop;

   // classify and pre-compute magnitudes and directions
   always_comb begin
      item_new.op        = req.cmd ? OP_CAST : OP_WRITE;
      item_new.cell_x    = req.cell_x;
      item_new.cell_y    = req.cell_y;
      item_new.cell_code = req.cell_code;
      item_new.player_x  = req.player_x;
      item_new.player_y  = req.player_y;
      item_new.neg_x     = req.ray_x[RAY_W-1];
      item_new.neg_y     = req.ray_y[RAY_W-1];
      item_new.mag_x     = req.ray_x[RAY_W-1] ? DIVS_W'(~req.ray_x + 16'd1) : req.ray_x;
      item_new.mag_y     = req.ray_y[RAY_W-1] ? DIVS_W'(~req.ray_y + 16'd1) : req.ray_y;
   end

   assign req.ready  = (count_ff != ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH));
   assign push       = req.valid && req.ready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + ($clog2(FIFO_DEPTH+1))'(push) - ($clog2(FIFO_DEPTH+1))'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/gdrc_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module gdrc_isqrt
   import gdrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0]      root,
   output gdrc_unit_stat_type     stat
);

   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [REM_W+1:0]  rem_sh, trial;

   // one result bit per cycle, two radicand bits consumed
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gdrc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module gdrc_divider
   import gdrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIVS_W-1:0] divisor,
   output logic [DIVD_W-1:0]      quotient,
   output gdrc_unit_stat_type     stat
);

   localparam int CNT_W = $clog2(DIVD_W);

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIVS_W:0]   rem_sh, diff;
   logic              fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      fits    = (rem_sh >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gdrc_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "grid_dda_ray_caster_macros.svh"
module gdrc_back
   import gdrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   input  wire gdrc_item_type item_head,
   output logic               item_pop,
   input  wire gdrc_cfg_type  cfg,
   gdrc_rsp_if.source         rsp
);

   gdrc_state_type state_ff, state_in;

   logic [CODE_W-1:0] map_mem [MAP_DEPTH];
   logic [CODE_W-1:0] rd_data_ff;
   logic [MAP_ADDR_W-1:0] rd_addr, wr_addr, clr_cnt_ff, clr_cnt_in;
   logic [CODE_W-1:0] wr_data;
   logic              wr_en;

   logic [POS_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [DIVS_W-1:0]  mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic               neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [DIST_W-1:0]  ix_ff, ix_in, iy_ff, iy_in, perp_ff, perp_in;
   logic [SIDE_W-1:0]  side_x_ff, side_x_in, side_y_ff, side_y_in;
   logic               yside_ff, yside_in, hit_ff, hit_in;
   logic [CODE_W-1:0]  target_ff, target_in;

   logic               rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic               rsp_yside_ff, rsp_yside_in;
   logic [CELL_W-1:0]  rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [DIST_W-1:0]  rsp_perp_ff, rsp_perp_in, rsp_sx_ff, rsp_sx_in;
   logic [DIST_W-1:0]  rsp_sy_ff, rsp_sy_in;

   logic               sqrt_start, div_start;
   logic [ROOT_W-1:0]  sqrt_root;
   logic [DIVD_W-1:0]  div_dividend, div_quotient;
   logic [DIVS_W-1:0]  div_divisor;
   gdrc_unit_stat_type sqrt_stat, div_stat;

   logic [COORD_W-1:0]     nx, ny, fx, fy, pc;
   logic [OFS_W-1:0]       ofs;
   logic [SIDE_PROD_W-1:0] prod;
   logic [EDGE_W-1:0]      edge_pos, edge_diff, num;
   logic [SIDE_W-1:0]      rem_x, rem_y;
   logic                   pneg;
   logic [POS_W-1:0]       ppos;
   logic [DIVS_W-1:0]      pmag;

   gdrc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({sq_ff, (2 * FRAC_BITS)'(0)}),
      .root     (sqrt_root),
      .stat     (sqrt_stat)
   );

   gdrc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   always_comb begin
      nx = neg_x_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
      ny = neg_y_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
      // neighbor on the entry side of the hit cell
      fx = cx_ff;
      fy = cy_ff;
      if (yside_ff) begin
         fy = neg_y_ff ? cy_ff + 1'b1 : cy_ff - 1'b1;
      end else begin
         fx = neg_x_ff ? cx_ff + 1'b1 : cx_ff - 1'b1;
      end
      pc   = yside_ff ? cy_ff : cx_ff;
      pneg = yside_ff ? neg_y_ff : neg_x_ff;
      ppos = yside_ff ? py_ff : px_ff;
      pmag = yside_ff ? mag_y_ff : mag_x_ff;
      edge_pos  = EDGE_W'(pneg ? pc + 1'b1 : pc) << FRAC_BITS;
      edge_diff = edge_pos - EDGE_W'(ppos);
      num       = edge_diff[EDGE_W-1] ? EDGE_W'(~edge_diff + 1'b1) : edge_diff;
      rem_x = (side_x_ff > SIDE_W'(ix_ff)) ? side_x_ff - SIDE_W'(ix_ff) : '0;
      rem_y = (side_y_ff > SIDE_W'(iy_ff)) ? side_y_ff - SIDE_W'(iy_ff) : '0;
      if (state_ff == ST_SIDE_X) begin
         ofs = neg_x_ff ? OFS_W'(px_ff[FRAC_BITS-1:0])
                        : ONE_UNIT - OFS_W'(px_ff[FRAC_BITS-1:0]);
         prod = SIDE_PROD_W'(ofs) * SIDE_PROD_W'(ix_ff);
      end else begin
         ofs = neg_y_ff ? OFS_W'(py_ff[FRAC_BITS-1:0])
                        : ONE_UNIT - OFS_W'(py_ff[FRAC_BITS-1:0]);
         prod = SIDE_PROD_W'(ofs) * SIDE_PROD_W'(iy_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      px_in = px_ff;       py_in = py_ff;
      mag_x_in = mag_x_ff; mag_y_in = mag_y_ff;
      neg_x_in = neg_x_ff; neg_y_in = neg_y_ff;
      cx_in = cx_ff;       cy_in = cy_ff;
      sq_in = sq_ff;       root_in = root_ff;
      ix_in = ix_ff;       iy_in = iy_ff;
      side_x_in = side_x_ff; side_y_in = side_y_ff;
      yside_in = yside_ff; hit_in = hit_ff;
      target_in = target_ff; perp_in = perp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_hit_in = rsp_hit_ff;   rsp_yside_in = rsp_yside_ff;
      rsp_cx_in = rsp_cx_ff;     rsp_cy_in = rsp_cy_ff;
      rsp_code_in = rsp_code_ff; rsp_perp_in = rsp_perp_ff;
      rsp_sx_in = rsp_sx_ff;     rsp_sy_in = rsp_sy_ff;
      item_pop     = 1'b0;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIVD_W'(root_ff);
      div_divisor  = mag_x_ff;
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      rd_addr = map_addr(cx_ff, cy_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == MAP_ADDR_W'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item_head.op == OP_WRITE) begin
                  if (cell_inside(COORD_W'(item_head.cell_x), COORD_W'(item_head.cell_y))) begin
                     wr_en   = 1'b1;
                     wr_addr = map_addr(COORD_W'(item_head.cell_x),
                                        COORD_W'(item_head.cell_y));
                     wr_data = item_head.cell_code;
                  end
               end else begin
                  px_in    = item_head.player_x;
                  py_in    = item_head.player_y;
                  mag_x_in = item_head.mag_x;
                  mag_y_in = item_head.mag_y;
                  neg_x_in = item_head.neg_x;
                  neg_y_in = item_head.neg_y;
                  cx_in    = COORD_W'(item_head.player_x[POS_W-1:FRAC_BITS]);
                  cy_in    = COORD_W'(item_head.player_y[POS_W-1:FRAC_BITS]);
                  hit_in   = 1'b0;
                  yside_in = 1'b0;
                  state_in = cell_inside(cx_in, cy_in) ? ST_SQ_X : ST_DONE;
               end
            end
         end
         ST_SQ_X: begin
            sq_in    = SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            sq_in    = sq_ff + SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);
            state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_stat.done) begin
               root_in  = sqrt_root;
               state_in = ST_DIVX_GO;
            end
         end
         ST_DIVX_GO: begin
            if (mag_x_ff == '0) begin
               ix_in    = DIST_MAX;
               state_in = ST_DIVY_GO;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVX_WAIT;
            end
         end
         ST_DIVX_WAIT: begin
            if (div_stat.done) begin
               ix_in    = sat_dist(div_quotient);
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            div_divisor = mag_y_ff;
            if (mag_y_ff == '0) begin
               iy_in    = DIST_MAX;
               state_in = ST_SIDE_X;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVY_WAIT;
            end
         end
         ST_DIVY_WAIT: begin
            if (div_stat.done) begin
               iy_in    = sat_dist(div_quotient);
               state_in = ST_SIDE_X;
            end
         end
         ST_SIDE_X: begin
            side_x_in = SIDE_W'(prod >> FRAC_BITS);
            state_in  = ST_SIDE_Y;
         end
         ST_SIDE_Y: begin
            side_y_in = SIDE_W'(prod >> FRAC_BITS);
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            // ties step along y
            if (side_x_ff < side_y_ff) begin
               side_x_in = side_x_ff + SIDE_W'(ix_ff);
               cx_in     = nx;
               yside_in  = 1'b0;
            end else begin
               side_y_in = side_y_ff + SIDE_W'(iy_ff);
               cy_in     = ny;
               yside_in  = 1'b1;
            end
            rd_addr  = map_addr(cx_in, cy_in);
            state_in = cell_inside(cx_in, cy_in) ? ST_CHECK : ST_DONE;
         end
         ST_CHECK: begin
            target_in = rd_data_ff;
            if (rd_data_ff == CODE_WALL) begin
               hit_in = 1'b1;
               if (cell_inside(fx, fy)) begin
                  rd_addr  = map_addr(fx, fy);
                  state_in = ST_NEIGH;
               end else begin
                  state_in = ST_PERP_GO;
               end
            end else if (rd_data_ff == CODE_DOOR) begin
               hit_in   = 1'b1;
               state_in = ST_PERP_GO;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_NEIGH: begin
            if (rd_data_ff == cfg.door_opened_code) begin
               target_in = cfg.door_side_code;
            end
            state_in = ST_PERP_GO;
         end
         ST_PERP_GO: begin
            div_divisor  = pmag;
            div_dividend = DIVD_W'({num, RAY_FRAC'(0)});
            if (pmag == '0) begin
               perp_in  = DIST_MAX;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_PERP_WAIT;
            end
         end
         ST_PERP_WAIT: begin
            if (div_stat.done) begin
               perp_in  = sat_dist(div_quotient);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               if (hit_ff) begin
                  rsp_cx_in    = cx_ff[CELL_W-1:0];
                  rsp_cy_in    = cy_ff[CELL_W-1:0];
                  rsp_yside_in = yside_ff;
                  rsp_code_in  = target_ff;
                  rsp_perp_in  = perp_ff;
                  rsp_sx_in    = sat_dist(DIVD_W'(rem_x));
                  rsp_sy_in    = sat_dist(DIVD_W'(rem_y));
               end else begin
                  rsp_cx_in    = '0;
                  rsp_cy_in    = '0;
                  rsp_yside_in = 1'b0;
                  rsp_code_in  = '0;
                  rsp_perp_in  = '0;
                  rsp_sx_in    = '0;
                  rsp_sy_in    = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;       py_ff <= py_in;
      mag_x_ff <= mag_x_in; mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in; neg_y_ff <= neg_y_in;
      cx_ff <= cx_in;       cy_ff <= cy_in;
      sq_ff <= sq_in;       root_ff <= root_in;
      ix_ff <= ix_in;       iy_ff <= iy_in;
      side_x_ff <= side_x_in; side_y_ff <= side_y_in;
      yside_ff <= yside_in; hit_ff <= hit_in;
      target_ff <= target_in; perp_ff <= perp_in;
      rsp_hit_ff <= rsp_hit_in;   rsp_yside_ff <= rsp_yside_in;
      rsp_cx_ff <= rsp_cx_in;     rsp_cy_ff <= rsp_cy_in;
      rsp_code_ff <= rsp_code_in; rsp_perp_ff <= rsp_perp_in;
      rsp_sx_ff <= rsp_sx_in;     rsp_sy_ff <= rsp_sy_in;
   end

   // map storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit_found   = rsp_hit_ff;
   assign rsp.hit_cell_x  = rsp_cx_ff;
   assign rsp.hit_cell_y  = rsp_cy_ff;
   assign rsp.hit_y_side  = rsp_yside_ff;
   assign rsp.target_code = rsp_code_ff;
   assign rsp.perp_dist   = rsp_perp_ff;
   assign rsp.side_dist_x = rsp_sx_ff;
   assign rsp.side_dist_y = rsp_sy_ff;

   `GDRC_ASSERT_IMPLIES(a_no_pop_in_clear, clock, reset, state_ff == ST_CLEAR, !item_pop)
   `GDRC_ASSERT_IMPLIES(a_div_idle_on_start, clock, reset, div_start, !div_stat.busy)
   `GDRC_ASSERT_IMPLIES(a_sqrt_idle_on_start, clock, reset, sqrt_start, !sqrt_stat.busy)
   `GDRC_ASSERT_NEXT(a_miss_fields_zero, clock, reset, (state_ff == ST_DONE) && !hit_ff && (!rsp_valid_ff || rsp.ready), rsp_valid_ff && (rsp_perp_ff == '0) && (rsp_code_ff == '0))

endmodule
`default_nettype wire

// File: hw/rtl/grid_dda_ray_caster.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  transaction
// req_bus   in         one map cell write or one ray cast
// rsp_bus   out        one hit report per ray cast, none per write
// csr_bus   in         one door code register write
//
// after reset the map is swept to zero, one cell a cycle; only the two queue
// entries take req transactions meanwhile; csr writes land throughout
// a cast that hits runs a bit-serial square root and three divisions, and each
// cell walked passes through the step and check states; a zero ray component
// skips its division, a ray that leaves the map skips the last one
// a two-entry queue lets req transactions land while a cast runs or a result
// waits on rsp_bus
module grid_dda_ray_caster
   import gdrc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   gdrc_req_if.sink   req_bus,
   gdrc_rsp_if.source rsp_bus,
   gdrc_csr_if.sink   csr_bus
);

   gdrc_cfg_type  cfg_ff, cfg_in;
   gdrc_item_type item_head;
   logic          item_valid, item_pop;

   // csr writes always land at once
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_DOOR_OPENED: cfg_in.door_opened_code = csr_bus.data;
            CSR_DOOR_SIDE:   cfg_in.door_side_code   = csr_bus.data;
            default:         cfg_in = cfg_ff;    // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.door_opened_code <= DOOR_OPENED_RESET;
         cfg_ff.door_side_code   <= DOOR_SIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and queue
   gdrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .item_pop   (item_pop),
      .item_valid (item_valid),
      .item_head  (item_head)
   );

   // back end: map storage and the grid walk
   gdrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_head  (item_head),
      .item_pop   (item_pop),
      .cfg        (cfg_ff),
      .rsp        (rsp_bus)
   );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import gdrc_pkg::*;

   // register index that the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'd7;
   localparam int WALK_SHIFT = 14;

   // one req transaction
   typedef struct {
      gdrc_op_type        op;
      bit [5:0]           cell_x;
      bit [5:0]           cell_y;
      bit [7:0]           cell_code;
      bit [15:0]          player_x;
      bit [15:0]          player_y;
      bit signed [15:0]   ray_x;
      bit signed [15:0]   ray_y;
   } cast_req_type;

   // one rsp transaction
   typedef struct {
      bit        hit_found;
      bit [5:0]  hit_cell_x;
      bit [5:0]  hit_cell_y;
      bit        hit_y_side;
      bit [7:0]  target_code;
      bit [17:0] perp_dist;
      bit [17:0] side_dist_x;
      bit [17:0] side_dist_y;
   } hit_type;

   // map shadow, door codes and the queue of hit reports still owed
   class ray_hit_board;
      bit [7:0] cells [MAP_DEPTH];
      bit [7:0] open_code;
      bit [7:0] side_code;
      hit_type  hits_due [$];
      int       errors;

      function new();
         foreach (cells[i]) cells[i] = 8'd0;
         open_code = DOOR_OPENED_RESET;
         side_code = DOOR_SIDE_RESET;
         errors    = 0;
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         errors++;
      endtask

      function longint unsigned root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint clip(longint v);
         return (v > longint'(DIST_MAX)) ? longint'(DIST_MAX) : v;
      endfunction

      // distance covered along the ray per grid unit on axis a
      function longint step_len(longint a, longint b);
         if (a == 0) return longint'(DIST_MAX);
         return clip(longint'(root(longint'((a * a + b * b) << (2 * FRAC_BITS))) / a));
      endfunction

      function bit on_map(longint x, longint y);
         return x >= 0 && x < MAP_WIDTH && y >= 0 && y < MAP_HEIGHT;
      endfunction

      function void note_req(cast_req_type r);
         hit_type h;
         longint px, py, ax, ay, ix, iy, dx, dy, cx, cy, sx, sy, fx, fy, e;
         bit     yside;
         bit [7:0] code, target;
         if (r.op == OP_WRITE) begin
            cells[{r.cell_y, r.cell_x}] = r.cell_code;
            return;
         end
         h = '{default: 0};
         yside = 0;
         px = longint'(r.player_x);
         py = longint'(r.player_y);
         ax = (r.ray_x < 0) ? -longint'(r.ray_x) : longint'(r.ray_x);
         ay = (r.ray_y < 0) ? -longint'(r.ray_y) : longint'(r.ray_y);
         ix = step_len(ax, ay);
         iy = step_len(ay, ax);
         cx = px >>> FRAC_BITS;
         cy = py >>> FRAC_BITS;
         sx = (r.ray_x < 0) ? -1 : 1;
         sy = (r.ray_y < 0) ? -1 : 1;
         if (!on_map(cx, cy)) begin
            hits_due.push_back(h);
            return;
         end
         // distance to the first cell edge on each axis
         dx = (r.ray_x < 0) ? px - (cx << FRAC_BITS) : ((cx + 1) << FRAC_BITS) - px;
         dy = (r.ray_y < 0) ? py - (cy << FRAC_BITS) : ((cy + 1) << FRAC_BITS) - py;
         dx = (dx * ix) >>> FRAC_BITS;
         dy = (dy * iy) >>> FRAC_BITS;
         forever begin
            // ties go along y
            if (dx < dy) begin
               dx += ix;
               cx += sx;
               yside = 0;
            end else begin
               dy += iy;
               cy += sy;
               yside = 1;
            end
            if (!on_map(cx, cy)) begin
               hits_due.push_back(h);
               return;
            end
            code = cells[cy * MAP_WIDTH + cx];
            if (code == CODE_WALL || code == CODE_DOOR) break;
         end
         target = code;
         if (code == CODE_WALL) begin
            fx = yside ? cx : cx - sx;
            fy = yside ? cy - sy : cy;
            if (on_map(fx, fy) && cells[fy * MAP_WIDTH + fx] == open_code)
               target = side_code;
         end
         h.hit_found   = 1;
         h.hit_cell_x  = cx[5:0];
         h.hit_cell_y  = cy[5:0];
         h.hit_y_side  = yside;
         h.target_code = target;
         if (!yside) begin
            e = ((sx > 0) ? cx : cx + 1) * (64'sd1 << FRAC_BITS) - px;
            if (e < 0) e = -e;
            h.perp_dist = 18'((ax == 0) ? longint'(DIST_MAX) : clip((e << WALK_SHIFT) / ax));
         end else begin
            e = ((sy > 0) ? cy : cy + 1) * (64'sd1 << FRAC_BITS) - py;
            if (e < 0) e = -e;
            h.perp_dist = 18'((ay == 0) ? longint'(DIST_MAX) : clip((e << WALK_SHIFT) / ay));
         end
         h.side_dist_x = 18'(clip((dx > ix) ? dx - ix : 0));
         h.side_dist_y = 18'(clip((dy > iy) ? dy - iy : 0));
         hits_due.push_back(h);
      endfunction

      task check_hit(hit_type got);
         hit_type w;
         if (hits_due.size() == 0) begin
            report("unexpected rsp transaction, hit_found", got.hit_found, -1);
            return;
         end
         w = hits_due.pop_front();
         if (got.hit_found != w.hit_found) report("hit_found", got.hit_found, w.hit_found);
         if (got.hit_cell_x != w.hit_cell_x) report("hit_cell_x", got.hit_cell_x, w.hit_cell_x);
         if (got.hit_cell_y != w.hit_cell_y) report("hit_cell_y", got.hit_cell_y, w.hit_cell_y);
         if (got.hit_y_side != w.hit_y_side) report("hit_y_side", got.hit_y_side, w.hit_y_side);
         if (got.target_code != w.target_code)
            report("target_code", got.target_code, w.target_code);
         if (got.perp_dist != w.perp_dist) report("perp_dist", got.perp_dist, w.perp_dist);
         if (got.side_dist_x != w.side_dist_x)
            report("side_dist_x", got.side_dist_x, w.side_dist_x);
         if (got.side_dist_y != w.side_dist_y)
            report("side_dist_y", got.side_dist_y, w.side_dist_y);
      endtask
   endclass

   logic clock;
   logic reset;
   bit   busy_free;   // when set, neither side idles
   ray_hit_board board;

   gdrc_req_if req_bus();
   gdrc_rsp_if rsp_bus();
   gdrc_csr_if csr_bus();

   grid_dda_ray_caster dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // safety net, far past the slowest legal run
   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

   function int draw_gap();
      return busy_free ? 0 : $urandom_range(0, 5);
   endfunction

   // push one req transaction, keeping valid high when no gap is drawn
   task send_req(cast_req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= r.op;
      req_bus.cell_x    <= r.cell_x;
      req_bus.cell_y    <= r.cell_y;
      req_bus.cell_code <= r.cell_code;
      req_bus.player_x  <= r.player_x;
      req_bus.player_y  <= r.player_y;
      req_bus.ray_x     <= r.ray_x;
      req_bus.ray_y     <= r.ray_y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_req(r);
   endtask

   task put_cell(bit [5:0] x, bit [5:0] y, bit [7:0] code);
      cast_req_type r;
      r = '{op: OP_WRITE, default: 0};
      r.cell_x = x;
      r.cell_y = y;
      r.cell_code = code;
      send_req(r);
   endtask

   task cast(bit [15:0] px, bit [15:0] py, bit signed [15:0] rx, bit signed [15:0] ry);
      cast_req_type r;
      r = '{op: OP_CAST, default: 0};
      r.player_x = px;
      r.player_y = py;
      r.ray_x = rx;
      r.ray_y = ry;
      send_req(r);
   endtask

   // csr transaction; the model follows only the decoded indexes
   task write_csr(bit [7:0] idx, bit [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_DOOR_OPENED) board.open_code = value;
      else if (idx == CSR_DOOR_SIDE) board.side_code = value;
   endtask

   // let the block drain, then give trailing map writes time to land
   task drain();
      req_bus.valid <= 1'b0;
      while (board.hits_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function bit signed [15:0] pick_ray();
      case ($urandom_range(0, 9))
         0: return 16'sd0;
         1: return 16'sh8000;
         2: return 16'sh7fff;
         3: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   function bit [7:0] pick_code();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: return CODE_WALL;
         8, 9, 10: return CODE_DOOR;
         11, 12, 13, 14: return board.open_code;
         15, 16: return 8'd0;
         default: return 8'($urandom);
      endcase
   endfunction

   // one phase of random traffic, map writes mixed with casts
   task random_phase(int count, int write_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < write_pct)
            put_cell(6'($urandom), 6'($urandom), pick_code());
         else
            cast(16'($urandom), 16'($urandom), pick_ray(), pick_ray());
      end
   endtask

   // result side: per transaction stall, then sample at the handshake edge
   initial begin
      hit_type got;
      int      gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.hit_found   = rsp_bus.hit_found;
         got.hit_cell_x  = rsp_bus.hit_cell_x;
         got.hit_cell_y  = rsp_bus.hit_cell_y;
         got.hit_y_side  = rsp_bus.hit_y_side;
         got.target_code = rsp_bus.target_code;
         got.perp_dist   = rsp_bus.perp_dist;
         got.side_dist_x = rsp_bus.side_dist_x;
         got.side_dist_y = rsp_bus.side_dist_y;
         board.check_hit(got);
      end
   end

   initial begin
      board = new();
      busy_free = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= OP_WRITE;
      req_bus.cell_x <= '0;
      req_bus.cell_y <= '0;
      req_bus.cell_code <= '0;
      req_bus.player_x <= '0;
      req_bus.player_y <= '0;
      req_bus.ray_x <= '0;
      req_bus.ray_y <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default door codes, plus a write the block must drop
      write_csr(CSR_DOOR_OPENED, DOOR_OPENED_RESET);
      write_csr(CSR_DOOR_SIDE, DOOR_SIDE_RESET);
      write_csr(CSR_UNUSED, 8'hff);

      // directed: empty map, ray walks off the edge
      cast(16'h1600, 16'h1600, 16'sd16384, 16'sd0);
      // wall behind an opened door along x
      put_cell(6'd10, 6'd5, CODE_WALL);
      put_cell(6'd9, 6'd5, DOOR_OPENED_RESET);
      cast(16'h1600, 16'h1600, 16'sd16384, 16'sd0);
      // closed door straight down, zero x component
      put_cell(6'd5, 6'd10, CODE_DOOR);
      cast(16'h1600, 16'h1600, 16'sd0, 16'sd16384);
      // diagonal from a cell center: equal side distances
      put_cell(6'd7, 6'd7, CODE_WALL);
      put_cell(6'd6, 6'd6, CODE_WALL);
      cast(16'h1600, 16'h1600, 16'sd16384, 16'sd16384);
      // corners and extreme rays
      put_cell(6'd0, 6'd0, CODE_WALL);
      put_cell(6'd63, 6'd63, 8'hff);
      cast(16'hffff, 16'hffff, 16'sh8000, 16'sh8000);
      cast(16'h0000, 16'h0000, 16'sh7fff, 16'sh7fff);
      cast(16'h0000, 16'h0000, 16'sh8000, 16'sd0);
      cast(16'h1600, 16'h1600, 16'sd0, 16'sd0);
      cast(16'h1600, 16'h1600, 16'sd0, -16'sd16384);
      cast(16'h2bff, 16'h1400, -16'sd1, 16'sd1);
      put_cell(6'd63, 6'd0, CODE_DOOR);
      cast(16'hfc00, 16'h03ff, 16'sd0, -16'sd1);
      cast(16'h1600, 16'h1600, -16'sd20000, 16'sd9);

      // random, default codes, both sides idling
      random_phase(330, 45);
      drain();

      // extremes: empty cells count as opened doors
      write_csr(CSR_DOOR_OPENED, 8'h00);
      write_csr(CSR_DOOR_SIDE, 8'hff);
      busy_free = 1;
      random_phase(360, 30);
      drain();

      write_csr(CSR_DOOR_OPENED, 8'hff);
      write_csr(CSR_DOOR_SIDE, 8'h00);
      busy_free = 0;
      random_phase(360, 30);
      drain();

      write_csr(CSR_DOOR_OPENED, 8'($urandom));
      write_csr(CSR_DOOR_SIDE, 8'($urandom));
      random_phase(360, 30);
      drain();

      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.hits_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/gdrc_pkg.sv
hw/rtl/gdrc_req_if.sv
hw/rtl/gdrc_rsp_if.sv
hw/rtl/gdrc_csr_if.sv
hw/rtl/gdrc_front.sv
hw/rtl/gdrc_isqrt.sv
hw/rtl/gdrc_divider.sv
hw/rtl/gdrc_back.sv
hw/rtl/grid_dda_ray_caster.sv
tb/tb.sv
